/* rtl/core/bqx_pkg.sv */
`default_nettype none

package bqx_pkg;

  // fixed field widths
  localparam int COEF_W     = 32;
  localparam int RATIO_W    = 27;
  localparam int RATIO_FRAC = 24;
  localparam int RAMP_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // defaults for the top level parameters
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 29;

  // largest ramp step, one over 200 in Q0.24
  localparam logic [RAMP_W-1:0] RAMP_MAX = RAMP_W'(83886);

  // filter taps: three feedforward, then two feedback
  localparam int NUM_TAPS = 5;
  localparam logic [2:0] TAP_X0 = 3'd0;
  localparam logic [2:0] TAP_X1 = 3'd1;
  localparam logic [2:0] TAP_X2 = 3'd2;
  localparam logic [2:0] TAP_Y1 = 3'd3;
  localparam logic [2:0] TAP_Y2 = 3'd4;
  localparam logic [2:0] TAP_LAST = 3'(NUM_TAPS - 1);

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF0    = 3'd0,
    REG_FF1    = 3'd1,
    REG_FF2    = 3'd2,
    REG_FB1    = 3'd3,
    REG_FB2    = 3'd4,
    REG_BYPASS = 3'd5,
    REG_STEP   = 3'd6
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_SUM,
    S_FILT,
    S_BMUL,
    S_BLEND
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/biquad_filter_with_crossfade.sv */
`default_nettype none

// channel   dir  handshake             payload
// s_        in   s_tvalid / s_tready   s_tdata: sample_in
// m_        out  m_tvalid / m_tready   m_tdata: sample_out
// cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// once a sample is accepted, the single shared multiplier sets the steps that
// follow in order before the output register loads and the next sample is taken:
// five filter products, the last sum, saturation, one blend product, blend.
// s_tready is high only while the sequencer is idle; a result waiting in the
// output register does not hold off the next sample, but the blend step waits
// for the output register to free up. cfg_ready is always high.
// rst is synchronous: coefficients clear, bypass on, ramp step at its maximum.
module biquad_filter_with_crossfade #(
  parameter int SAMPLE_BITS    = bqx_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqx_pkg::COEF_FRAC_BITS_DEF,
  localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  input  wire logic [DATA_W-1:0]              s_tdata,   // sample_in
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  output      logic [DATA_W-1:0]              m_tdata,   // sample_out
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [bqx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bqx_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bqx_pkg::*;

  localparam int PROD_W = COEF_W + SAMPLE_BITS + 1;
  localparam int ACC_W  = PROD_W + 3;
  localparam int BL_W   = PROD_W + 1;

  localparam logic signed [ACC_W-1:0] ACC_ROUND =
    ACC_W'(longint'(1) <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] ACC_HI =
    ACC_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1));
  localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI - ACC_W'(1);
  localparam logic signed [BL_W-1:0] BL_ROUND =
    BL_W'(longint'(1) <<< (RATIO_FRAC - 1));
  localparam logic signed [BL_W-1:0] BL_HI = BL_W'(ACC_HI);
  localparam logic signed [BL_W-1:0] BL_LO = BL_W'(ACC_LO);
  localparam logic signed [RATIO_W-1:0] RATIO_ONE =
    RATIO_W'(longint'(1) <<< RATIO_FRAC);

  // configuration registers
  logic signed [COEF_W-1:0] coef [NUM_TAPS];
  logic                     bypass_mode;
  logic [RAMP_W-1:0]        ramp_step;

  // filter and blend state
  logic signed [SAMPLE_BITS-1:0] x_prev1, x_prev2, y_prev1, y_prev2;
  logic                          first_pending;
  logic signed [RATIO_W-1:0]     blend_ratio;

  // datapath registers
  state_t                        state, state_next;
  logic [2:0]                    cnt;
  logic signed [SAMPLE_BITS-1:0] x_cur;
  logic signed [SAMPLE_BITS-1:0] filt;
  logic signed [PROD_W-1:0]      prod;
  logic                          prod_neg;
  logic signed [ACC_W-1:0]       acc;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  // combinational signals
  logic                          s_accept, cfg_accept, out_load;
  logic signed [COEF_W-1:0]      mul_a;
  logic signed [SAMPLE_BITS:0]   mul_b;
  logic signed [PROD_W-1:0]      mul_p;
  logic signed [ACC_W-1:0]       acc_add, acc_sh;
  logic signed [SAMPLE_BITS-1:0] filt_sat;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [BL_W-1:0]        bl_rnd, bl_sh, bl_sum;
  logic signed [SAMPLE_BITS-1:0] bl_sat;
  logic [RAMP_W-1:0]             step_eff;
  logic                          bypass_new;

  assign cfg_ready  = 1'b1;
  assign s_accept   = s_tvalid && s_tready;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign m_tdata    = DATA_W'($unsigned(out_sample));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_accept) state_next = S_MAC;
      S_MAC:   if (cnt == TAP_LAST) state_next = S_SUM;
      S_SUM:   state_next = S_FILT;
      S_FILT:  state_next = S_BMUL;
      S_BMUL:  state_next = S_BLEND;
      S_BLEND: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs and multiplier operands
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    mul_a    = coef[cnt];
    mul_b    = '0;
    unique case (state)
      S_IDLE:  s_tready = 1'b1;
      S_MAC: begin
        case (cnt)
          TAP_X0:  mul_b = {x_cur[SAMPLE_BITS-1], x_cur};
          TAP_X1:  mul_b = {x_prev1[SAMPLE_BITS-1], x_prev1};
          TAP_X2:  mul_b = {x_prev2[SAMPLE_BITS-1], x_prev2};
          TAP_Y1:  mul_b = {y_prev1[SAMPLE_BITS-1], y_prev1};
          TAP_Y2:  mul_b = {y_prev2[SAMPLE_BITS-1], y_prev2};
          default: mul_b = '0;
        endcase
      end
      S_BMUL: begin
        mul_a = COEF_W'(blend_ratio);
        mul_b = diff;
      end
      S_BLEND: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // shared multiplier
  assign mul_p = mul_a * mul_b;

  // accumulate the registered product, feedback taps subtract
  assign acc_add = prod_neg ? acc - ACC_W'(prod) : acc + ACC_W'(prod);

  // round half up already folded into acc, then drop fraction and saturate
  assign acc_sh = acc >>> COEF_FRAC_BITS;
  always_comb begin
    if (acc_sh > ACC_HI) filt_sat = SAMPLE_BITS'(ACC_HI);
    else if (acc_sh < ACC_LO) filt_sat = SAMPLE_BITS'(ACC_LO);
    else filt_sat = SAMPLE_BITS'(acc_sh);
  end

  // crossfade term
  assign diff   = {filt[SAMPLE_BITS-1], filt} - {x_cur[SAMPLE_BITS-1], x_cur};
  assign bl_rnd = BL_W'(prod) + BL_ROUND;
  assign bl_sh  = bl_rnd >>> RATIO_FRAC;
  assign bl_sum = bl_sh + BL_W'(filt);
  always_comb begin
    if (bl_sum > BL_HI) bl_sat = SAMPLE_BITS'(BL_HI);
    else if (bl_sum < BL_LO) bl_sat = SAMPLE_BITS'(BL_LO);
    else bl_sat = SAMPLE_BITS'(bl_sum);
  end

  // ramp step clamped to its legal range
  always_comb begin
    if (ramp_step == '0) step_eff = RAMP_W'(1);
    else if (ramp_step > RAMP_MAX) step_eff = RAMP_MAX;
    else step_eff = ramp_step;
  end

  // bypass value after a write, for reloading the ratio
  assign bypass_new = (cfg_index == REG_BYPASS) ? cfg_data[0] : bypass_mode;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_MAC) cnt <= cnt + 3'd1;
      else cnt <= '0;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // filter state, ratio and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TAPS; i++) coef[i] <= '0;
      bypass_mode   <= 1'b1;
      ramp_step     <= RAMP_MAX;
      x_prev1       <= '0;
      x_prev2       <= '0;
      y_prev1       <= '0;
      y_prev2       <= '0;
      first_pending <= 1'b1;
      blend_ratio   <= -RATIO_ONE;
    end else begin
      // first sample after reset or a write inside the register map seeds the history
      if (s_accept && first_pending) begin
        first_pending <= 1'b0;
        y_prev1       <= SAMPLE_BITS'(s_tdata);
        y_prev2       <= SAMPLE_BITS'(s_tdata);
        x_prev1       <= '0;
        x_prev2       <= '0;
      end
      // shift the history once the filter output is known
      if (state == S_FILT) begin
        x_prev2 <= x_prev1;
        x_prev1 <= x_cur;
        y_prev2 <= y_prev1;
        y_prev1 <= filt_sat;
      end
      // ratio ramp
      if (out_load) begin
        if (blend_ratio <= -RATIO_ONE) blend_ratio <= blend_ratio;
        else if (blend_ratio > RATIO_W'(0))
          blend_ratio <= blend_ratio - RATIO_W'(step_eff);
        else blend_ratio <= blend_ratio - RATIO_W'({step_eff, 1'b0});
      end
      // register writes
      if (cfg_accept) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_FF0, REG_FF1, REG_FF2, REG_FB1, REG_FB2:
            coef[cfg_index] <= COEF_W'(cfg_data);
          REG_BYPASS: bypass_mode <= cfg_data[0];
          REG_STEP:   ramp_step   <= cfg_data[RAMP_W-1:0];
          default: ;
        endcase
        if (cfg_index <= REG_STEP) begin
          first_pending <= 1'b1;
          blend_ratio   <= bypass_new ? -RATIO_ONE : RATIO_ONE;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      x_cur <= SAMPLE_BITS'(s_tdata);
      acc   <= ACC_ROUND;
    end
    unique case (state)
      S_MAC: begin
        prod     <= mul_p;
        prod_neg <= (cnt >= TAP_Y1);
        if (cnt != TAP_X0) acc <= acc_add;
      end
      S_SUM:  acc  <= acc_add;
      S_FILT: filt <= filt_sat;
      S_BMUL: prod <= mul_p;
      default: ;
    endcase
    // output select by blend region
    if (out_load) begin
      if (blend_ratio <= -RATIO_ONE) out_sample <= x_cur;
      else if (blend_ratio > RATIO_W'(0)) out_sample <= filt;
      else out_sample <= bl_sat;
    end
  end

  // an accepted sample keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("sequencer idle right after an accepted sample");

  // a result appears only out of the blend step
  a_out_from_blend: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_BLEND))
    else $error("output valid rose outside the blend step");

  // without a register write the ratio never rises
  a_ratio_falls: assert property (@(posedge clk) disable iff (rst)
    !cfg_accept |=> (blend_ratio <= $past(blend_ratio)))
    else $error("blend ratio rose without a register write");

endmodule

`default_nettype wire

/* tb/sv/biquad_filter_with_crossfade_tb.sv */
`timescale 1ns / 1ps

module biquad_filter_with_crossfade_tb;
  import bqx_pkg::*;

  localparam int SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int FRAC_W   = COEF_FRAC_BITS_DEF;
  localparam int DATA_W   = ((SAMPLE_W + 7) / 8) * 8;

  localparam longint SAMPLE_HI   = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_LO   = -SAMPLE_HI - 1;
  localparam longint RATIO_UNITY = longint'(1) << RATIO_FRAC;

  // extreme samples at the field width
  localparam logic signed [SAMPLE_W-1:0] X_MAX = SAMPLE_W'(SAMPLE_HI);
  localparam logic signed [SAMPLE_W-1:0] X_MIN = SAMPLE_W'(SAMPLE_LO);

  // index past the end of the register map, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS  = 1650;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 30;
  localparam int WALK_STEP     = 4096;
  localparam int MAX_PRINTS    = 20;

  // coefficient presets in Q2.29, second-order butterworth near fs/10
  localparam logic signed [COEF_W-1:0] COEF_ONE = 1 <<< FRAC_W;
  localparam logic signed [COEF_W-1:0] LP_B0    = 36238787;
  localparam logic signed [COEF_W-1:0] LP_B1    = 72477573;
  localparam logic signed [COEF_W-1:0] HP_B0    = 343006825;
  localparam logic signed [COEF_W-1:0] HP_B1    = -686013650;
  localparam logic signed [COEF_W-1:0] BW_A1    = -613643452;
  localparam logic signed [COEF_W-1:0] BW_A2    = 221727687;

  typedef enum int {WAVE_NOISE, WAVE_WALK, WAVE_EDGES} wave_t;
  typedef enum int {RUN_FADE, RUN_MIXED, RUN_RAW} run_kind_t;

  // predicts sample_out for each accepted sample and checks arrivals in order
  class crossfade_scoreboard;
    logic signed [COEF_W-1:0]   coef [NUM_TAPS];
    logic                       bypass_on;
    logic [RAMP_W-1:0]          step_reg;
    logic signed [SAMPLE_W-1:0] x_d1, x_d2, y_d1, y_d2;
    logic                       seed_next;
    logic signed [RATIO_W-1:0]  ratio;
    logic [SAMPLE_W-1:0]        out_fifo [$];
    int errors, results_seen, writes;
    int n_filtered, n_faded, n_raw, n_clipped;

    function new();
      foreach (coef[i]) coef[i] = '0;
      bypass_on = 1'b1;
      step_reg  = RAMP_MAX;
      x_d1 = '0;
      x_d2 = '0;
      y_d1 = '0;
      y_d2 = '0;
      seed_next = 1'b1;
      ratio = start_ratio();
      errors = 0;
      results_seen = 0;
      writes = 0;
      n_filtered = 0;
      n_faded = 0;
      n_raw = 0;
      n_clipped = 0;
    endfunction

    function logic signed [RATIO_W-1:0] start_ratio();
      return bypass_on ? RATIO_W'(-RATIO_UNITY) : RATIO_W'(RATIO_UNITY);
    endfunction

    function longint saturate(longint v);
      if (v > SAMPLE_HI) return SAMPLE_HI;
      if (v < SAMPLE_LO) return SAMPLE_LO;
      return v;
    endfunction

    // register write: store, then restart seeding and the blend ramp
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      writes++;
      case (idx)
        REG_FF0, REG_FF1, REG_FF2, REG_FB1, REG_FB2: coef[idx] = data;
        REG_BYPASS: bypass_on = data[0];
        REG_STEP: step_reg = data[RAMP_W-1:0];
        default: return;
      endcase
      seed_next = 1'b1;
      ratio = start_ratio();
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] raw);
      logic signed [SAMPLE_W-1:0] x;
      longint acc, filt, val, prod, dec, r;
      x = raw;
      // first sample after a write seeds the output history
      if (seed_next) begin
        seed_next = 1'b0;
        y_d1 = x;
        y_d2 = x;
        x_d1 = '0;
        x_d2 = '0;
      end
      acc = longint'(coef[TAP_X0]) * x + longint'(coef[TAP_X1]) * x_d1
          + longint'(coef[TAP_X2]) * x_d2 - longint'(coef[TAP_Y1]) * y_d1
          - longint'(coef[TAP_Y2]) * y_d2;
      acc = (acc + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
      filt = saturate(acc);
      if (filt != acc) n_clipped++;
      x_d2 = x_d1;
      x_d1 = x;
      y_d2 = y_d1;
      y_d1 = filt[SAMPLE_W-1:0];
      // step clamps to the legal range
      if (step_reg == '0) dec = 1;
      else if (step_reg > RAMP_MAX) dec = RAMP_MAX;
      else dec = step_reg;
      // blend region follows the ratio
      r = ratio;
      if (r <= -RATIO_UNITY) begin
        val = x;
        n_raw++;
      end else if (r > 0) begin
        val = filt;
        ratio = RATIO_W'(r - dec);
        n_filtered++;
      end else begin
        prod = r * (filt - x);
        val = saturate(filt + ((prod + (longint'(1) << (RATIO_FRAC - 1))) >>> RATIO_FRAC));
        ratio = RATIO_W'(r - 2 * dec);
        n_faded++;
      end
      out_fifo.push_back(val[SAMPLE_W-1:0]);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch: %s", what);
    endtask

    task check_result(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (out_fifo.size() == 0) begin
        report_mismatch($sformatf("unexpected sample_out %0d", $signed(got)));
        return;
      end
      want = out_fifo.pop_front();
      results_seen++;
      if (got !== want)
        report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
                                  results_seen, $signed(got), $signed(want)));
    endtask

    task flush_check();
      logic [SAMPLE_W-1:0] want;
      while (out_fifo.size() > 0) begin
        want = out_fifo.pop_front();
        report_mismatch($sformatf("expected sample_out %0d never came", $signed(want)));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata;   // sample_in
  logic                  m_tvalid;
  logic                  m_tready;
  logic [DATA_W-1:0]     m_tdata;   // sample_out
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  crossfade_scoreboard sb = new();
  int  n_sent;
  int  quiet;
  int  unused_writes;
  int  n_runs;
  bit  steady;

  biquad_filter_with_crossfade #(
    .SAMPLE_BITS(SAMPLE_W),
    .COEF_FRAC_BITS(FRAC_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // observe every handshake at the clock edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_sample(s_tdata[SAMPLE_W-1:0]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata[SAMPLE_W-1:0]);
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // downstream ready: mostly short open stretches with occasional long ones, short and occasional long stalls
  initial begin
    int run;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      case ($urandom_range(0, 99)) inside
        [0:54]:  run = 0;
        [55:84]: run = $urandom_range(1, 3);
        [85:96]: run = $urandom_range(4, 15);
        default: run = $urandom_range(30, 80);
      endcase
      if (run > 0) begin
        m_tready <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    if (steady) return 0;
    case ($urandom_range(0, 99)) inside
      [0:49]:  return 0;
      [50:84]: return $urandom_range(1, 3);
      [85:96]: return $urandom_range(4, 12);
      default: return $urandom_range(20, 60);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(wave_t wave,
                                                             logic signed [SAMPLE_W-1:0] prev);
    int v;
    if (wave == WAVE_NOISE || $urandom_range(0, 9) < 2) return SAMPLE_W'($urandom());
    if (wave == WAVE_EDGES) begin
      case ($urandom_range(0, 5))
        0: return X_MAX;
        1: return X_MIN;
        2: return 0;
        3: return -1;
        4: return X_MAX - SAMPLE_W'(1);
        default: return X_MIN + SAMPLE_W'(1);
      endcase
    end
    v = int'(prev) + int'($urandom_range(0, 2 * WALK_STEP)) - WALK_STEP;
    if (v > SAMPLE_HI) v = int'(SAMPLE_HI);
    else if (v < SAMPLE_LO) v = int'(SAMPLE_LO);
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2, 3, 4: return CFG_DATA_W'(longint'($urandom_range(0, 32'd1610612736)) - 805306368);
      default: return CFG_DATA_W'(longint'($urandom_range(0, 32'd268435456)) - 134217728);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_step();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return CFG_DATA_W'(RAMP_MAX);
      3: return CFG_DATA_W'(RAMP_MAX) + 1;
      4: return $urandom() | 32'h0001_FFFF;
      5, 6: return $urandom();
      default: return $urandom_range(1, RAMP_MAX);
    endcase
  endfunction

  // steps large enough that a run reaches the crossfade region and, for the larger steps, the raw region
  function automatic logic [CFG_DATA_W-1:0] fade_step();
    case ($urandom_range(0, 4))
      0: return CFG_DATA_W'(RAMP_MAX);
      1: return $urandom() | 32'h0001_FFFF;
      2: return $urandom_range(RAMP_MAX + 1, 17'h1FFFF);
      default: return $urandom_range(60000, RAMP_MAX);
    endcase
  endfunction

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_coefs(input logic signed [COEF_W-1:0] b0, b1, b2, a1, a2);
    program_reg(REG_FF0, b0);
    program_reg(REG_FF1, b1);
    program_reg(REG_FF2, b2);
    program_reg(REG_FB1, a1);
    program_reg(REG_FB2, a2);
  endtask

  // called right after a sample request completes, or when the input is idle
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DATA_W'(x[SAMPLE_W-1:0]);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
  endtask

  // hold the input until every predicted output has come back
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (sb.results_seen < n_sent) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic configure_run(input run_kind_t kind, output int span);
    cfg_reg_t r;
    int wrote;
    wait_results_drained();
    case (kind)
      RUN_FADE: begin
        case ($urandom_range(0, 2))
          0: program_coefs(LP_B0, LP_B1, LP_B0, BW_A1, BW_A2);
          1: program_coefs(HP_B0, HP_B1, HP_B0, BW_A1, BW_A2);
          default: program_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
        endcase
        program_reg(REG_STEP, fade_step());
        program_reg(REG_BYPASS, $urandom() & 32'hFFFF_FFFE);
        span = $urandom_range(320, 440);
      end
      RUN_MIXED: begin
        // random subset of registers with random values
        wrote = 0;
        r = r.first();
        do begin
          if ($urandom_range(0, 1)) begin
            if (r == REG_STEP) program_reg(r, rand_step());
            else if (r == REG_BYPASS) program_reg(r, $urandom());
            else program_reg(r, rand_coef());
            wrote++;
          end
          r = r.next();
        end while (r != r.first());
        if (wrote == 0) program_reg(REG_STEP, rand_step());
        span = $urandom_range(20, 150);
      end
      default: begin
        if ($urandom_range(0, 1)) program_reg(REG_FF0, rand_coef());
        program_reg(REG_BYPASS, $urandom() | 32'h1);
        span = $urandom_range(20, 80);
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      program_reg(REG_UNUSED, $urandom());
      unused_writes++;
    end
    n_runs++;
  endtask

  initial begin
    int k, span, total;
    logic signed [SAMPLE_W-1:0] level;
    run_kind_t kind;
    wave_t wave;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    n_sent = 0;
    quiet = 0;
    unused_writes = 0;
    n_runs = 1;
    steady = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state: bypass on, raw samples pass
    send_sample(0);
    send_sample(X_MAX);
    send_sample(X_MIN);
    send_sample(-1);

    // extreme coefficients, bypass cleared through junk upper bits, oversized step
    wait_results_drained();
    program_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    program_reg(REG_BYPASS, 32'hFFFF_FFFE);
    program_reg(REG_STEP, 32'hFFFF_FFFF);
    n_runs++;
    send_sample(X_MAX);
    send_sample(X_MIN);
    send_sample(X_MAX);
    send_sample(0);
    send_sample(X_MIN);

    // zero step acts as the smallest step
    wait_results_drained();
    program_reg(REG_STEP, 0);
    n_runs++;
    send_sample(X_MIN);
    send_sample(4242);
    send_sample(X_MAX);

    // write past the register map must not reseed the history
    wait_results_drained();
    program_reg(REG_UNUSED, $urandom());
    unused_writes++;
    send_sample(-77);

    // unity pass-through filter
    wait_results_drained();
    program_coefs(COEF_ONE, 0, 0, 0, 0);
    n_runs++;
    send_sample(X_MIN);
    send_sample(X_MAX);
    send_sample(12345);

    // half gain, ties round toward plus infinity
    wait_results_drained();
    program_reg(REG_FF0, COEF_ONE >>> 1);
    n_runs++;
    send_sample(1);
    send_sample(-1);
    send_sample(3);
    send_sample(-3);

    // random runs, half of them drawn as filtered-to-raw fade runs
    total = 0;
    level = 0;
    while (total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9)) inside
        [0:4]:   kind = RUN_FADE;
        [5:7]:   kind = RUN_MIXED;
        default: kind = RUN_RAW;
      endcase
      configure_run(kind, span);
      // last run trimmed so the sample count lands on the target
      if (span > RANDOM_ITEMS - total) span = RANDOM_ITEMS - total;
      case ($urandom_range(0, 3))
        0: wave = WAVE_NOISE;
        1: wave = WAVE_EDGES;
        default: wave = WAVE_WALK;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      for (k = 0; k < span; k++) begin
        if (k > 0 && $urandom_range(0, 199) == 0) wait_results_drained();
        level = pick_sample(wave, level);
        send_sample(level);
      end
      total += span;
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flush_check();

    $display("summary: %0d samples over %0d settings, %0d register writes (%0d unmapped)",
             n_sent, n_runs, sb.writes, unused_writes);
    $display("summary: %0d filtered, %0d crossfaded, %0d raw outputs, %0d clipped filter sums",
             sb.n_filtered, sb.n_faded, sb.n_raw, sb.n_clipped);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
